[rtl/assert_macros.svh]
// Assertion macros for the checker file of the lexer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the clock after the antecedent.
`define TLL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer assertion failed");

// The consequent must hold in the same clock as the antecedent.
`define TLL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer assertion failed");

`endif

[rtl/tll_pkg.sv]
// Types and constants shared by the lexer modules.
package tll_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [4:0] token_kind;
    logic [5:0] token_length;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [4:0] kind;
    logic [5:0] length;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t first;
    tok_t second;
  } entry_t;

  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_ASSIGN  = 3'd1,
    ST_COMMENT = 3'd2,
    ST_NUM     = 3'd3,
    ST_ID      = 3'd4
  } scan_state_t;

  localparam logic [4:0] TK_EOF    = 5'd0;
  localparam logic [4:0] TK_ERROR  = 5'd1;
  localparam logic [4:0] TK_IF     = 5'd2;
  localparam logic [4:0] TK_ID     = 5'd10;
  localparam logic [4:0] TK_NUM    = 5'd11;
  localparam logic [4:0] TK_ASSIGN = 5'd12;
  localparam logic [4:0] TK_EQ     = 5'd13;
  localparam logic [4:0] TK_LT     = 5'd14;
  localparam logic [4:0] TK_PLUS   = 5'd15;
  localparam logic [4:0] TK_MINUS  = 5'd16;
  localparam logic [4:0] TK_TIMES  = 5'd17;
  localparam logic [4:0] TK_OVER   = 5'd18;
  localparam logic [4:0] TK_LPAREN = 5'd19;
  localparam logic [4:0] TK_RPAREN = 5'd20;
  localparam logic [4:0] TK_SEMI   = 5'd21;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

endpackage

[rtl/tiny_language_lexer_core.sv]
// A token is written into the token queue, and out_valid offers it from there.
// Throughput: one character per cycle while the four-entry token queue has room.
// An item that yields two tokens fills one queue entry, whose tokens leave in order.
// Characters that yield no token never enter the queue.
// Reset (synchronous, rst_n low) returns the scanner to start state and empties the queue.
module tiny_language_lexer_core #(
  parameter int MAX_TOKEN_LEN = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tll_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tll_pkg::out_item_t out_data
);

  logic            push, pop, full, empty;
  tll_pkg::entry_t push_data, head;

  tll_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (full),
    .push      (push),
    .push_data (push_data)
  );

  tll_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  tll_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/tll_front.sv]
// Scanner front end: accepts characters, runs the automaton and queues tokens.
module tll_front #(
  parameter int MAX_TOKEN_LEN = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tll_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output tll_pkg::entry_t   push_data
);

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [5:0] LEN_MAX   = 6'(MAX_TOKEN_LEN);

  localparam logic [47:0] KW_TEXT [8] = '{
    {"if", 32'd0}, {"then", 16'd0}, {"else", 16'd0}, {"end", 24'd0},
    "repeat", {"until", 8'd0}, {"read", 16'd0}, {"write", 8'd0}
  };
  localparam logic [2:0] KW_LEN [8] = '{3'd2, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd5};

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
    logic [47:0] row;
    row = KW_TEXT[k];
    if (pos > 3'd5) begin
      return 8'd0;
    end
    return row[{3'd5 - pos, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] kw_step(input logic [7:0] cand, input logic [5:0] len,
                                         input logic [7:0] c);
    logic [7:0] keep;
    keep = '0;
    for (int k = 0; k < 8; k++) begin
      keep[k] = cand[k] && (len < {3'b000, KW_LEN[k]}) && (kw_char(k, len[2:0]) == c);
    end
    return keep;
  endfunction

  function automatic logic [4:0] id_kind(input logic [7:0] cand, input logic [5:0] len);
    logic [4:0] kind;
    kind = tll_pkg::TK_ID;
    for (int k = 7; k >= 0; k--) begin
      if (cand[k] && ({3'b000, KW_LEN[k]} == len)) begin
        kind = tll_pkg::TK_IF + 5'(k);
      end
    end
    return kind;
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    case (c)
      CH_EQ:     return tll_pkg::TK_EQ;
      CH_LT:     return tll_pkg::TK_LT;
      CH_PLUS:   return tll_pkg::TK_PLUS;
      CH_MINUS:  return tll_pkg::TK_MINUS;
      CH_STAR:   return tll_pkg::TK_TIMES;
      CH_SLASH:  return tll_pkg::TK_OVER;
      CH_LPAREN: return tll_pkg::TK_LPAREN;
      CH_RPAREN: return tll_pkg::TK_RPAREN;
      CH_SEMI:   return tll_pkg::TK_SEMI;
      default:   return tll_pkg::TK_ERROR;
    endcase
  endfunction

  tll_pkg::scan_state_t st_r, st_nxt, start_st;
  logic [5:0]           len_r, len_nxt, len_inc, start_len;
  logic [7:0]           cand_r, cand_nxt, start_cand;
  logic                 pre_emit, start_emit, restart;
  tll_pkg::tok_t        pre_tok, start_tok;
  logic [7:0]           c;
  logic                 eoi, is_digit, is_letter, accept;

  assign c         = in_data.ch;
  assign eoi       = in_data.end_of_input;
  assign is_digit  = (c >= 8'h30) && (c <= 8'h39);
  assign is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  assign len_inc   = (len_r < LEN_MAX) ? len_r + 6'd1 : len_r;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    start_st   = tll_pkg::ST_START;
    start_len  = 6'd0;
    start_cand = 8'hFF;
    start_emit = 1'b0;
    start_tok  = '{kind: tll_pkg::TK_EOF, length: 6'd0};
    if (eoi) begin
      start_emit = 1'b1;
    end else if (is_digit) begin
      start_st  = tll_pkg::ST_NUM;
      start_len = 6'd1;
    end else if (is_letter) begin
      start_st   = tll_pkg::ST_ID;
      start_len  = 6'd1;
      start_cand = kw_step(8'hFF, 6'd0, c);
    end else if (c == CH_COLON) begin
      start_st  = tll_pkg::ST_ASSIGN;
      start_len = 6'd1;
    end else if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL)) begin
      start_st = tll_pkg::ST_START;
    end else if (c == CH_LBRACE) begin
      start_st = tll_pkg::ST_COMMENT;
    end else begin
      start_emit = 1'b1;
      start_tok  = '{kind: single_kind(c), length: 6'd1};
    end
  end

  always_comb begin
    st_nxt   = st_r;
    len_nxt  = len_r;
    cand_nxt = cand_r;
    pre_emit = 1'b0;
    pre_tok  = '{kind: tll_pkg::TK_EOF, length: 6'd0};
    restart  = 1'b0;
    case (st_r)
      tll_pkg::ST_COMMENT: begin
        if (eoi || (c == CH_RBRACE)) begin
          pre_emit = eoi;
          st_nxt   = tll_pkg::ST_START;
          len_nxt  = 6'd0;
          cand_nxt = 8'hFF;
        end
      end
      tll_pkg::ST_ASSIGN: begin
        pre_emit = 1'b1;
        if (!eoi && (c == CH_EQ)) begin
          pre_tok  = '{kind: tll_pkg::TK_ASSIGN, length: len_inc};
          st_nxt   = tll_pkg::ST_START;
          len_nxt  = 6'd0;
          cand_nxt = 8'hFF;
        end else begin
          pre_tok = '{kind: tll_pkg::TK_ERROR, length: len_r};
          restart = 1'b1;
        end
      end
      tll_pkg::ST_NUM: begin
        if (!eoi && is_digit) begin
          len_nxt = len_inc;
        end else begin
          pre_emit = 1'b1;
          pre_tok  = '{kind: tll_pkg::TK_NUM, length: len_r};
          restart  = 1'b1;
        end
      end
      tll_pkg::ST_ID: begin
        if (!eoi && is_letter) begin
          len_nxt  = len_inc;
          cand_nxt = kw_step(cand_r, len_r, c);
        end else begin
          pre_emit = 1'b1;
          pre_tok  = '{kind: id_kind(cand_r, len_r), length: len_r};
          restart  = 1'b1;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase
    if (restart) begin
      st_nxt   = start_st;
      len_nxt  = start_len;
      cand_nxt = start_cand;
    end
  end

  assign push             = accept && (pre_emit || (restart && start_emit));
  assign push_data.two    = pre_emit && restart && start_emit;
  assign push_data.first  = pre_emit ? pre_tok : start_tok;
  assign push_data.second = start_tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= tll_pkg::ST_START;
      len_r  <= 6'd0;
      cand_r <= 8'hFF;
    end else if (accept) begin
      st_r   <= st_nxt;
      len_r  <= len_nxt;
      cand_r <= cand_nxt;
    end
  end

endmodule

[rtl/tll_fifo.sv]
// Short token queue between the scanner front end and the output stage.
module tll_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tll_pkg::entry_t push_data,
  input  logic            pop,
  output tll_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  tll_pkg::entry_t               mem_r [tll_pkg::QUEUE_DEPTH];
  logic [tll_pkg::PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [tll_pkg::CNT_W-1:0]     count_r, count_nxt;

  assign head  = mem_r[rd_ptr_r];
  assign full  = (count_r == tll_pkg::CNT_W'(tll_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/tll_emit.sv]
// Output stage: sends the one or two tokens of each queue entry in order.
module tll_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  tll_pkg::entry_t    head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tll_pkg::out_item_t out_data
);

  logic          sel_r, sel_nxt;
  logic          last;
  tll_pkg::tok_t tok;

  assign out_valid             = !empty;
  assign tok                   = sel_r ? head.second : head.first;
  assign last                  = !head.two || sel_r;
  assign out_data.token_kind   = tok.kind;
  assign out_data.token_length = tok.length;
  assign out_data.last         = last;
  assign pop                   = out_valid && out_ready && last;

  always_comb begin
    sel_nxt = sel_r;
    if (out_valid && out_ready) begin
      sel_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

[rtl/tll_checker.sv]
// Port-level checker for the lexer and its bind to the top level.
`include "assert_macros.svh"

module tll_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input tll_pkg::out_item_t out_data
);

  `TLL_ASSERT_NEXT(a_out_valid_held, out_valid && !out_ready, out_valid)
  `TLL_ASSERT_NEXT(a_out_data_held, out_valid && !out_ready, $stable(out_data))
  `TLL_ASSERT_NEXT(a_second_token_follows, out_valid && !out_data.last, out_valid)
  `TLL_ASSERT_NOW(a_eof_empty,
    out_valid && (out_data.token_kind == tll_pkg::TK_EOF),
    (out_data.token_length == 6'd0) && out_data.last)
  `TLL_ASSERT_NOW(a_assign_len,
    out_valid && (out_data.token_kind == tll_pkg::TK_ASSIGN),
    out_data.token_length == 6'd2)

endmodule

bind tiny_language_lexer_core tll_checker u_tll_checker (.*);

[tb/sv/tiny_language_lexer_core_tb.sv]
// Testbench for the lexer core: directed and random character streams against a predictor.
`timescale 1ns / 100ps

module tiny_language_lexer_core_tb;

  localparam int MAX_LEN = 40;
  localparam int NUM_RANDOM = 525;

  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_TIMES  = "*";
  localparam logic [7:0] CH_OVER   = "/";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_COLON  = ":";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       chk;
    logic [4:0] kind;
    logic [5:0] len;
  } stim_row_t;

  localparam int NUM_DIRECTED = 25;
  localparam stim_row_t DIR_ROWS [0:NUM_DIRECTED-1] = '{
    '{8'h00,     1'b1, 1'b1, tll_pkg::TK_EOF,    6'd0},
    '{8'hFF,     1'b0, 1'b1, tll_pkg::TK_ERROR,  6'd1},
    '{8'h80,     1'b0, 1'b1, tll_pkg::TK_ERROR,  6'd1},
    '{8'h00,     1'b0, 1'b1, tll_pkg::TK_ERROR,  6'd1},
    '{CH_EQ,     1'b0, 1'b1, tll_pkg::TK_EQ,     6'd1},
    '{CH_LT,     1'b0, 1'b1, tll_pkg::TK_LT,     6'd1},
    '{CH_PLUS,   1'b0, 1'b1, tll_pkg::TK_PLUS,   6'd1},
    '{CH_MINUS,  1'b0, 1'b1, tll_pkg::TK_MINUS,  6'd1},
    '{CH_TIMES,  1'b0, 1'b1, tll_pkg::TK_TIMES,  6'd1},
    '{CH_OVER,   1'b0, 1'b1, tll_pkg::TK_OVER,   6'd1},
    '{CH_LPAREN, 1'b0, 1'b1, tll_pkg::TK_LPAREN, 6'd1},
    '{CH_RPAREN, 1'b0, 1'b1, tll_pkg::TK_RPAREN, 6'd1},
    '{CH_SEMI,   1'b0, 1'b1, tll_pkg::TK_SEMI,   6'd1},
    '{CH_COLON,  1'b0, 1'b0, tll_pkg::TK_EOF,    6'd0},
    '{CH_EQ,     1'b0, 1'b1, tll_pkg::TK_ASSIGN, 6'd2},
    '{CH_COLON,  1'b0, 1'b0, tll_pkg::TK_EOF,    6'd0},
    '{8'hA5,     1'b1, 1'b1, tll_pkg::TK_EOF,    6'd0},
    '{CH_LBRACE, 1'b0, 1'b0, tll_pkg::TK_EOF,    6'd0},
    '{"x",       1'b0, 1'b0, tll_pkg::TK_EOF,    6'd0},
    '{8'h5A,     1'b1, 1'b1, tll_pkg::TK_EOF,    6'd0},
    '{"i",       1'b0, 1'b0, tll_pkg::TK_EOF,    6'd0},
    '{"f",       1'b0, 1'b0, tll_pkg::TK_EOF,    6'd0},
    '{CH_SEMI,   1'b0, 1'b1, tll_pkg::TK_SEMI,   6'd1},
    '{"9",       1'b0, 1'b0, tll_pkg::TK_EOF,    6'd0},
    '{8'h00,     1'b1, 1'b1, tll_pkg::TK_EOF,    6'd0}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  tll_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  tll_pkg::out_item_t out_data;

  logic       row_chk;
  logic [4:0] row_kind;
  logic [5:0] row_len;
  logic       quiet = 1'b0;
  int         err_count = 0;
  int         stall_left = 0;

  tll_pkg::scan_state_t lx_state;
  logic [5:0]           lx_len;
  logic [7:0]           lx_cand;
  tll_pkg::tok_t        lex_out[$];
  tll_pkg::out_item_t   expected_tokens[$];
  tll_pkg::in_item_t    char_plan[$];
  tll_pkg::out_item_t   want;
  tll_pkg::tok_t        tk;

  tiny_language_lexer_core #(
    .MAX_TOKEN_LEN(MAX_LEN)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int kw_len(input int k);
    case (k)
      0: return 2;
      1, 2, 6: return 4;
      3: return 3;
      4: return 6;
      default: return 5;
    endcase
  endfunction

  function automatic logic [7:0] kw_byte(input int k, input int p);
    logic [47:0] w;
    case (k)
      0: w = "if";
      1: w = "then";
      2: w = "else";
      3: w = "end";
      4: w = "repeat";
      5: w = "until";
      6: w = "read";
      default: w = "write";
    endcase
    return w[(kw_len(k) - 1 - p) * 8 +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [4:0] op_kind(input logic [7:0] c);
    case (c)
      CH_EQ:     return tll_pkg::TK_EQ;
      CH_LT:     return tll_pkg::TK_LT;
      CH_PLUS:   return tll_pkg::TK_PLUS;
      CH_MINUS:  return tll_pkg::TK_MINUS;
      CH_TIMES:  return tll_pkg::TK_TIMES;
      CH_OVER:   return tll_pkg::TK_OVER;
      CH_LPAREN: return tll_pkg::TK_LPAREN;
      CH_RPAREN: return tll_pkg::TK_RPAREN;
      CH_SEMI:   return tll_pkg::TK_SEMI;
      default:   return tll_pkg::TK_ERROR;
    endcase
  endfunction

  function automatic logic [7:0] op_char(input int i);
    case (i)
      0: return CH_EQ;
      1: return CH_LT;
      2: return CH_PLUS;
      3: return CH_MINUS;
      4: return CH_TIMES;
      5: return CH_OVER;
      6: return CH_LPAREN;
      7: return CH_RPAREN;
      default: return CH_SEMI;
    endcase
  endfunction

  function automatic logic [4:0] id_kind();
    for (int k = 0; k < 8; k++) begin
      if (lx_cand[k] && kw_len(k) == lx_len) return tll_pkg::TK_IF + 5'(k);
    end
    return tll_pkg::TK_ID;
  endfunction

  task automatic lex_clear();
    lx_state = tll_pkg::ST_START;
    lx_len = '0;
    lx_cand = '1;
  endtask

  task automatic lex_emit(input logic [4:0] kind, input logic [5:0] len);
    tll_pkg::tok_t t;
    t.kind = kind;
    t.length = len;
    lex_out.push_back(t);
  endtask

  task automatic lex_save(input logic [7:0] c, input logic letter);
    logic [7:0] keep;
    if (letter) begin
      keep = '0;
      for (int k = 0; k < 8; k++) begin
        if (lx_cand[k] && lx_len < kw_len(k) && kw_byte(k, lx_len) == c) keep[k] = 1'b1;
      end
      lx_cand = keep;
    end
    if (lx_len < MAX_LEN) lx_len = lx_len + 6'd1;
  endtask

  task automatic lex_restart(input logic [7:0] c, input logic e);
    lex_clear();
    if (e) begin
      lex_emit(tll_pkg::TK_EOF, 6'd0);
    end else if (is_digit(c)) begin
      lx_state = tll_pkg::ST_NUM;
      lex_save(c, 1'b0);
    end else if (is_letter(c)) begin
      lx_state = tll_pkg::ST_ID;
      lex_save(c, 1'b1);
    end else if (c == CH_COLON) begin
      lx_state = tll_pkg::ST_ASSIGN;
      lex_save(c, 1'b0);
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
    end else if (c == CH_LBRACE) begin
      lx_state = tll_pkg::ST_COMMENT;
    end else begin
      lex_emit(op_kind(c), 6'd1);
    end
  endtask

  task automatic lex_char(input logic [7:0] c, input logic e);
    case (lx_state)
      tll_pkg::ST_COMMENT: begin
        if (e) begin
          lex_clear();
          lex_emit(tll_pkg::TK_EOF, 6'd0);
        end else if (c == CH_RBRACE) begin
          lex_clear();
        end
      end
      tll_pkg::ST_ASSIGN: begin
        if (!e && c == CH_EQ) begin
          lex_save(c, 1'b0);
          lex_emit(tll_pkg::TK_ASSIGN, lx_len);
          lex_clear();
        end else begin
          lex_emit(tll_pkg::TK_ERROR, lx_len);
          lex_restart(c, e);
        end
      end
      tll_pkg::ST_NUM: begin
        if (!e && is_digit(c)) begin
          lex_save(c, 1'b0);
        end else begin
          lex_emit(tll_pkg::TK_NUM, lx_len);
          lex_restart(c, e);
        end
      end
      tll_pkg::ST_ID: begin
        if (!e && is_letter(c)) begin
          lex_save(c, 1'b1);
        end else begin
          lex_emit(id_kind(), lx_len);
          lex_restart(c, e);
        end
      end
      default: lex_restart(c, e);
    endcase
  endtask

  // Each accepted transaction is predicted first, then the oldest token is checked.
  always @(posedge clk) begin
    if (!rst_n) begin
      lex_clear();
      expected_tokens.delete();
    end else begin
      if (in_valid && in_ready) begin
        lex_out.delete();
        lex_char(in_data.ch, in_data.end_of_input);
        if (row_chk && lex_out.size() > 0) begin
          tk = lex_out.pop_back();
          tk.kind = row_kind;
          tk.length = row_len;
          lex_out.push_back(tk);
        end
        for (int i = 0; i < lex_out.size(); i++) begin
          want.token_kind = lex_out[i].kind;
          want.token_length = lex_out[i].length;
          want.last = (i == lex_out.size() - 1);
          expected_tokens.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token: expected none, got kind %0d length %0d last %0d",
                   $time, out_data.token_kind, out_data.token_length, out_data.last);
          err_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_data !== want) begin
            $display({"%0t: token mismatch: expected kind %0d length %0d last %0d, ",
                      "got kind %0d length %0d last %0d"},
                     $time, want.token_kind, want.token_length, want.last,
                     out_data.token_kind, out_data.token_length, out_data.last);
            err_count++;
          end
        end
      end
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      stall_left = idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 3) == 0) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  task automatic plan_item(input logic [7:0] c, input logic e);
    tll_pkg::in_item_t it;
    it.ch = c;
    it.end_of_input = e;
    char_plan.push_back(it);
  endtask

  task automatic plan_lexeme();
    int r;
    int n;
    int k;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      k = $urandom_range(0, 7);
      for (int i = 0; i < kw_len(k); i++) plan_item(kw_byte(k, i), 1'b0);
      if ($urandom_range(0, 1)) plan_item(CH_SPACE, 1'b0);
    end else if (r < 30) begin
      if ($urandom_range(0, 2) == 0) begin
        k = $urandom_range(0, 7);
        n = $urandom_range(1, kw_len(k) + 1);
        for (int i = 0; i < n; i++) begin
          plan_item(i < kw_len(k) ? kw_byte(k, i) : rand_letter(), 1'b0);
        end
      end else begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(35, 50) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) plan_item(rand_letter(), 1'b0);
      end
      if ($urandom_range(0, 1)) plan_item(CH_SPACE, 1'b0);
    end else if (r < 43) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(38, 48) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) plan_item(8'("0" + $urandom_range(0, 9)), 1'b0);
    end else if (r < 51) begin
      plan_item(CH_COLON, 1'b0);
      plan_item(CH_EQ, 1'b0);
    end else if (r < 62) begin
      plan_item(op_char($urandom_range(0, 8)), 1'b0);
    end else if (r < 70) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(0, 2);
        plan_item(k == 0 ? CH_SPACE : (k == 1 ? CH_TAB : CH_NL), 1'b0);
      end
    end else if (r < 76) begin
      plan_item(CH_LBRACE, 1'b0);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(0, 255));
        plan_item(c == CH_RBRACE ? CH_SPACE : c, 1'b0);
      end
      if ($urandom_range(0, 9) != 0) plan_item(CH_RBRACE, 1'b0);
    end else if (r < 82) begin
      plan_item(8'($urandom_range(0, 255)), 1'b1);
    end else if (r < 88) begin
      plan_item(CH_COLON, 1'b0);
      plan_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      plan_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic send_item(input tll_pkg::in_item_t it, input logic chk,
                           input logic [4:0] kind, input logic [5:0] len);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    row_chk <= chk;
    row_kind <= kind;
    row_len <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int sent;
    tll_pkg::in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    row_chk = 1'b0;
    row_kind = tll_pkg::TK_EOF;
    row_len = '0;
    sent = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      it.ch = DIR_ROWS[i].ch;
      it.end_of_input = DIR_ROWS[i].eoi;
      send_item(it, DIR_ROWS[i].chk, DIR_ROWS[i].kind, DIR_ROWS[i].len);
    end
    while (sent < NUM_RANDOM) begin
      plan_lexeme();
      while (char_plan.size() > 0) begin
        sent++;
        quiet = (sent >= 250 && sent < 330);
        send_item(char_plan.pop_front(), 1'b0, tll_pkg::TK_EOF, 6'd0);
      end
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
